// File: rtl/core/hidrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_pkg
// shared types and constants of the report descriptor parser
// ----------------------------------------------------------------------------
package hidrd_pkg;

	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	localparam logic [3:0] TAG_INPUT     = 4'd8;
	localparam logic [3:0] TAG_USAGE     = 4'd0;
	localparam logic [3:0] TAG_USAGE_PG  = 4'd0;
	localparam logic [3:0] TAG_LOG_MIN   = 4'd1;
	localparam logic [3:0] TAG_LOG_MAX   = 4'd2;
	localparam logic [3:0] TAG_PHY_MIN   = 4'd3;
	localparam logic [3:0] TAG_PHY_MAX   = 4'd4;
	localparam logic [3:0] TAG_RPT_SIZE  = 4'd7;
	localparam logic [3:0] TAG_RPT_ID    = 4'd8;
	localparam logic [3:0] TAG_RPT_COUNT = 4'd9;

	// globals that stay constant across the records of one input item
	typedef struct packed {
		logic [31:0] upage;
		logic [31:0] lmin;
		logic [31:0] lmax;
		logic [31:0] pmin;
		logic [31:0] pmax;
		logic [31:0] rsize;
		logic [31:0] rid;
	} glob_t;

	// globals at the start of a descriptor: size eight, all else zero
	localparam glob_t GLOB_RESET = '{upage: 32'd0, lmin: 32'd0, lmax: 32'd0,
		pmin: 32'd0, pmax: 32'd0, rsize: 32'd8, rid: 32'd0};

endpackage

// File: rtl/core/hid_report_descriptor_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser
// short-item report descriptor parser emitting one record per input field
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid, in_stall   | desc_byte, first_byte: one byte request
//  out     | out_valid, out_stall | page .. last_field: one field record
//
//  headers and data bytes are taken one per cycle while no input item is
//  emitting records; a record waiting at a stalled output does not hold them
//  an input main item blocks input while its min(count, MAX_FIELDS) records
//  are requested and read from the usage memory (a registered read), and
//  while out_stall holds a record still in the pipe
//  records leave through one output register; out_stall holds it
//  arst_n clears the parse state; the usage memory needs no clear since
//  only entries below the usage count are ever used
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser #(
	parameter int USAGE_SLOTS = 32,
	parameter int MAX_FIELDS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  desc_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] page,
	output logic [31:0] usage,
	output logic [31:0] log_lo,
	output logic [31:0] log_hi,
	output logic [31:0] phys_lo,
	output logic [31:0] phys_hi,
	output logic [31:0] field_bits,
	output logic [31:0] bit_offset,
	output logic [31:0] field_id,
	output logic [31:0] main_flags,
	output logic        last_field
);

	localparam int UW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
	localparam int CW = $clog2(USAGE_SLOTS + 1);
	localparam int FW = $clog2(MAX_FIELDS + 1);

	// parse state
	logic [2:0]  left_q;
	logic [1:0]  type_q;
	logic [3:0]  tag_q;
	logic [31:0] accum_q;
	logic [1:0]  bidx_q;
	hidrd_pkg::glob_t glob_q;
	logic [31:0] count_q;
	logic [CW-1:0] ucnt_q;
	logic [31:0] total_q;

	// usage memory
	logic [31:0] umem [USAGE_SLOTS];
	logic [31:0] urd_q;

	// emit sequencer
	logic          emit_q;   // records in progress
	logic [FW-1:0] idx_q;    // next record to request
	logic [FW-1:0] cnt_q;    // records in this item
	logic [31:0]   flags_q;
	logic          rd_s1;    // memory read pending for record
	logic          rlast_s1;
	logic [31:0]   roff_s1;
	logic          rzero_s1; // no usage at all

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	// globals are read when a record loads the output register, so input
	// waits only while records are still being requested or read
	assign in_stall = emit_q || rd_s1;

	logic acc;
	assign acc = in_valid && !in_stall;

	// byte decode, with restart on first_byte
	logic [2:0]  left_e;
	logic [1:0]  bidx_e;
	logic [1:0]  sc;
	logic [2:0]  nleft;
	logic        hdr;
	logic        exec;
	logic [1:0]  typ;
	logic [3:0]  tg;
	logic [31:0] dat;
	logic [31:0] cnt32;

	always_comb begin
		left_e = first_byte ? 3'd0 : left_q;
		bidx_e = first_byte ? 2'd0 : bidx_q;
		hdr = (left_e == 3'd0);
		sc = desc_byte[1:0];
		if (hdr) begin
			nleft = (sc == 2'd3) ? 3'd4 : {1'b0, sc};
			typ = desc_byte[3:2];
			tg = desc_byte[7:4];
			dat = '0;
		end else begin
			nleft = left_e - 3'd1;
			typ = type_q;
			tg = tag_q;
			dat = (first_byte ? 32'd0 : accum_q) | ({24'd0, desc_byte} << {bidx_e, 3'b000});
		end
		exec = (nleft == 3'd0);
		cnt32 = first_byte ? 32'd1 : count_q;
	end

	logic [CW-1:0] ucnt_e;
	assign ucnt_e = first_byte ? '0 : ucnt_q;

	// item execution: next globals, count and usage count
	hidrd_pkg::glob_t glob_n;
	logic [31:0]      count_n;
	logic [CW-1:0]    ucnt_n;
	logic             emit_go;

	always_comb begin
		glob_n = first_byte ? hidrd_pkg::GLOB_RESET : glob_q;
		count_n = cnt32;
		ucnt_n = ucnt_e;
		emit_go = 1'b0;
		if (exec) begin
			case (typ)
				hidrd_pkg::TYPE_MAIN: begin
					// locals survive an emitting input item until its last record
					emit_go = (tg == hidrd_pkg::TAG_INPUT) && (cnt32 != 32'd0);
					ucnt_n = emit_go ? ucnt_e : '0;
				end
				hidrd_pkg::TYPE_GLOBAL: begin
					case (tg)
						hidrd_pkg::TAG_USAGE_PG:  glob_n.upage = dat;
						hidrd_pkg::TAG_LOG_MIN:   glob_n.lmin = dat;
						hidrd_pkg::TAG_LOG_MAX:   glob_n.lmax = dat;
						hidrd_pkg::TAG_PHY_MIN:   glob_n.pmin = dat;
						hidrd_pkg::TAG_PHY_MAX:   glob_n.pmax = dat;
						hidrd_pkg::TAG_RPT_SIZE:  glob_n.rsize = dat;
						hidrd_pkg::TAG_RPT_ID:    glob_n.rid = dat;
						hidrd_pkg::TAG_RPT_COUNT: count_n = dat;
						default: ;
					endcase
				end
				hidrd_pkg::TYPE_LOCAL: begin
					if (tg == hidrd_pkg::TAG_USAGE && 32'(ucnt_e) < 32'(USAGE_SLOTS))
						ucnt_n = ucnt_e + CW'(1);
				end
				default: ;
			endcase
		end
	end

	logic [UW-1:0] ridx;
	always_comb begin
		if ({1'b0, idx_q} < {1'b0, ucnt_q[CW-1:0]} && 32'(idx_q) < 32'(USAGE_SLOTS))
			ridx = UW'(idx_q);
		else
			ridx = '0;
	end

	always_ff @(posedge clk) begin
		if (acc && exec && typ == hidrd_pkg::TYPE_LOCAL && tg == hidrd_pkg::TAG_USAGE
				&& 32'(ucnt_e) < 32'(USAGE_SLOTS))
			umem[UW'(ucnt_e)] <= dat;
		if (emit_q && out_free)
			urd_q <= umem[ridx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			type_q <= '0;
			tag_q <= '0;
			accum_q <= '0;
			bidx_q <= '0;
			glob_q <= hidrd_pkg::GLOB_RESET;
			count_q <= 32'd1;
			ucnt_q <= '0;
			total_q <= '0;
			emit_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			flags_q <= '0;
			rd_s1 <= 1'b0;
			rlast_s1 <= 1'b0;
			roff_s1 <= '0;
			rzero_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// acc and emit_q never hold together, so each register is written once
			if (acc) begin
				glob_q <= glob_n;
				count_q <= count_n;
				ucnt_q <= ucnt_n;
				if (first_byte)
					total_q <= '0;
				left_q <= nleft;
				type_q <= typ;
				tag_q <= tg;
				accum_q <= dat;
				bidx_q <= hdr ? 2'd0 : bidx_e + 2'd1;
				if (emit_go) begin
					emit_q <= 1'b1;
					idx_q <= '0;
					cnt_q <= (cnt32 > 32'(MAX_FIELDS)) ? FW'(MAX_FIELDS)
						: FW'(cnt32);
					flags_q <= dat;
				end
			end

			// record sequencing: read issued in emit stage, record registered next
			if (out_free) begin
				rd_s1 <= emit_q;
				if (emit_q) begin
					rlast_s1 <= (idx_q + FW'(1) == cnt_q);
					roff_s1 <= total_q;
					rzero_s1 <= (ucnt_q == '0);
					total_q <= total_q + glob_q.rsize;
					idx_q <= idx_q + FW'(1);
					if (idx_q + FW'(1) == cnt_q) begin
						emit_q <= 1'b0;
						ucnt_q <= '0;
					end
				end
				out_valid <= rd_s1;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free && rd_s1) begin
			page <= glob_q.upage;
			usage <= rzero_s1 ? 32'd0 : urd_q;
			log_lo <= glob_q.lmin;
			log_hi <= glob_q.lmax;
			phys_lo <= glob_q.pmin;
			phys_hi <= glob_q.pmax;
			field_bits <= glob_q.rsize;
			bit_offset <= roff_s1;
			field_id <= glob_q.rid;
			main_flags <= flags_q;
			last_field <= rlast_s1;
		end
	end

endmodule
